@@ rtl/core/icct_pkg.sv @@
// Shared types and constants for the inverse colour transform and clip unit.
// Used by icct_comp_tail and inverse_color_transform_clip_unit; no dependencies.
package icct_pkg;

  // Default number of fraction bits on the fixed-point samples.
  localparam int unsigned FRAC_BITS = 13;

  // Field widths of the streams.
  localparam int unsigned IN_W   = 32;
  localparam int unsigned OUT_W  = 17;
  localparam int unsigned RANGE_W = 2 * OUT_W;

  // Working width of the transformed values; wide enough that nothing wraps.
  localparam int unsigned VAL_W = 36;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = RANGE_W;

  // Clip range after reset: minimum 0, maximum 255.
  localparam logic [RANGE_W-1:0] CLIP_RANGE_RST = RANGE_W'(34'd33423360);

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE,
    REG_SHIFT_0,
    REG_SHIFT_1,
    REG_SHIFT_2,
    REG_RANGE_0,
    REG_RANGE_1,
    REG_RANGE_2
  } icct_reg_e;

  // Transform modes; the unused code behaves as the ICT.
  typedef enum logic [1:0] {
    MODE_RCT_INT,
    MODE_RCT_FIX,
    MODE_ICT
  } icct_mode_e;

  // Load enables for the rounding and clipping stages.
  typedef struct packed {
    logic ld3;
    logic ld4;
  } icct_stage_en_t;

endpackage

@@ rtl/core/icct_comp_tail.sv @@
// Rounding, level shift and clipping stages for one colour component.
// Depends on icct_pkg; instantiated three times by the top level.
module icct_comp_tail import icct_pkg::*; #(
  parameter int unsigned FracBits = FRAC_BITS
) (
  input  logic                      clk_i,
  input  icct_stage_en_t            en_i,
  input  logic                      round_en_i,
  input  logic signed [VAL_W-1:0]   val_i,
  input  logic signed [OUT_W-1:0]   shift_i,
  input  logic [RANGE_W-1:0]        range_i,
  output logic signed [OUT_W-1:0]   res_o
);

  localparam logic signed [VAL_W-1:0] Half = VAL_W'(1) <<< (FracBits - 1);

  logic signed [VAL_W-1:0] adj;
  logic signed [VAL_W-1:0] rnd;
  logic signed [VAL_W-1:0] val3_d, val3_q;
  logic signed [VAL_W-1:0] shifted;
  logic signed [OUT_W-1:0] rng_min, rng_max;
  logic signed [OUT_W-1:0] res4_d, res4_q;

  // Round to nearest with ties away from zero: a non-positive value takes
  // one less bias, which turns the floor shift into the required ceiling.
  always_comb begin
    adj    = val_i + Half - VAL_W'(val_i <= 0);
    rnd    = adj >>> FracBits;
    val3_d = round_en_i ? rnd : val_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.ld3) begin
      val3_q <= val3_d;
    end
  end

  // Level shift, then clip; the minimum test takes priority.
  always_comb begin
    rng_min = range_i[OUT_W-1:0];
    rng_max = range_i[RANGE_W-1:OUT_W];
    shifted = val3_q + VAL_W'(shift_i);
    if (shifted < VAL_W'(rng_min)) begin
      res4_d = rng_min;
    end else if (shifted > VAL_W'(rng_max)) begin
      res4_d = rng_max;
    end else begin
      res4_d = shifted[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.ld4) begin
      res4_q <= res4_d;
    end
  end

  assign res_o = res4_q;

endmodule

@@ rtl/core/inverse_color_transform_clip_unit.sv @@
// Throughput: one pixel per cycle; each of the four stages holds one pixel and
// a stalled output only blocks the input once every stage is occupied.
// Stages: coefficient multiplies, transform sums, rounding, shift and clip.
// Reset clears the stage valid bits and returns the registers to mode 0,
// zero level shifts and a clip range of 0 to 255.
// Top level of the inverse RCT / ICT unit; depends on icct_pkg and icct_comp_tail.
module inverse_color_transform_clip_unit import icct_pkg::*; #(
  parameter int unsigned FracBits = FRAC_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Configuration write port.
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata_i,
  // Input stream.
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [3*IN_W-1:0]       s_axis_tdata,  // luma_in, chroma_b_in, chroma_r_in
  // Output stream.
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [55:0]             m_axis_tdata   // red_out, green_out, blue_out, zero pad
);

  // Coefficients scaled by 2^FracBits and truncated; negative ones are
  // negated before the multiply so that the floor shift matches.
  localparam int unsigned CoefW = FracBits + 2;
  localparam int unsigned PW    = IN_W + CoefW;
  localparam logic signed [CoefW-1:0] CoefRV =
    CoefW'((64'd1402 << FracBits) / 64'd1000);
  localparam logic signed [CoefW-1:0] CoefGU =
    CoefW'(64'd0 - (64'd34413 << FracBits) / 64'd100000);
  localparam logic signed [CoefW-1:0] CoefGV =
    CoefW'(64'd0 - (64'd71414 << FracBits) / 64'd100000);
  localparam logic signed [CoefW-1:0] CoefBU =
    CoefW'((64'd1772 << FracBits) / 64'd1000);

  // Configuration registers.
  logic [1:0]              mode_q;
  logic signed [OUT_W-1:0] shift_q [3];
  logic [RANGE_W-1:0]      range_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_RCT_INT;
      for (int i = 0; i < 3; i++) begin
        shift_q[i] <= '0;
        range_q[i] <= CLIP_RANGE_RST;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MODE:    mode_q     <= cfg_wdata_i[1:0];
        REG_SHIFT_0: shift_q[0] <= cfg_wdata_i[OUT_W-1:0];
        REG_SHIFT_1: shift_q[1] <= cfg_wdata_i[OUT_W-1:0];
        REG_SHIFT_2: shift_q[2] <= cfg_wdata_i[OUT_W-1:0];
        REG_RANGE_0: range_q[0] <= cfg_wdata_i;
        REG_RANGE_1: range_q[1] <= cfg_wdata_i;
        REG_RANGE_2: range_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic is_rct;
  logic round_en;
  assign is_rct   = (mode_q == MODE_RCT_INT) || (mode_q == MODE_RCT_FIX);
  assign round_en = (mode_q != MODE_RCT_INT);

  // Stage handshake: a stage loads when it is empty or its successor moves.
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;
  icct_stage_en_t tail_en;

  assign rdy4 = !v4_q || m_axis_tready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign s_axis_tready = rdy1;
  assign tail_en.ld3 = rdy3 && v2_q;
  assign tail_en.ld4 = rdy4 && v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // Stage one: unpack, multiply by the ICT coefficients and form u + v.
  logic signed [IN_W-1:0] in_y, in_u, in_v;
  logic signed [IN_W-1:0] y1_q, u1_q, v1d_q;
  logic signed [IN_W:0]   sum_uv_q;
  logic signed [PW-1:0]   p_rv_q, p_gu_q, p_gv_q, p_bu_q;

  assign in_y = s_axis_tdata[IN_W-1:0];
  assign in_u = s_axis_tdata[2*IN_W-1:IN_W];
  assign in_v = s_axis_tdata[3*IN_W-1:2*IN_W];

  always_ff @(posedge clk_i) begin
    if (rdy1 && s_axis_tvalid) begin
      y1_q     <= in_y;
      u1_q     <= in_u;
      v1d_q    <= in_v;
      sum_uv_q <= (IN_W+1)'(in_u) + (IN_W+1)'(in_v);
      p_rv_q   <= PW'(in_v) * PW'(CoefRV);
      p_gu_q   <= PW'(in_u) * PW'(CoefGU);
      p_gv_q   <= PW'(in_v) * PW'(CoefGV);
      p_bu_q   <= PW'(in_u) * PW'(CoefBU);
    end
  end

  // Stage two: floor-shift the products and form the transform sums.
  logic signed [PW-1:0]    sh_rv, sh_gu, sh_gv, sh_bu;
  logic signed [VAL_W-1:0] m_rv, m_gu, m_gv, m_bu;
  logic signed [IN_W:0]    quarter;
  logic signed [VAL_W-1:0] g_rct, y_ext;
  logic signed [VAL_W-1:0] val2_d [3];
  logic signed [VAL_W-1:0] val2_q [3];

  always_comb begin
    sh_rv   = p_rv_q >>> FracBits;
    sh_gu   = p_gu_q >>> FracBits;
    sh_gv   = p_gv_q >>> FracBits;
    sh_bu   = p_bu_q >>> FracBits;
    m_rv    = sh_rv[VAL_W-1:0];
    m_gu    = sh_gu[VAL_W-1:0];
    m_gv    = sh_gv[VAL_W-1:0];
    m_bu    = sh_bu[VAL_W-1:0];
    quarter = sum_uv_q >>> 2;
    y_ext   = VAL_W'(y1_q);
    g_rct   = y_ext - VAL_W'(quarter);
    if (is_rct) begin
      val2_d[0] = VAL_W'(v1d_q) + g_rct;
      val2_d[1] = g_rct;
      val2_d[2] = VAL_W'(u1_q) + g_rct;
    end else begin
      val2_d[0] = y_ext + m_rv;
      val2_d[1] = y_ext + m_gu + m_gv;
      val2_d[2] = y_ext + m_bu;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      val2_q <= val2_d;
    end
  end

  // Stages three and four: rounding, level shift and clip per component.
  logic signed [OUT_W-1:0] res [3];

  for (genvar c = 0; c < 3; c++) begin : g_comp
    icct_comp_tail #(
      .FracBits(FracBits)
    ) u_tail (
      .clk_i      (clk_i),
      .en_i       (tail_en),
      .round_en_i (round_en),
      .val_i      (val2_q[c]),
      .shift_i    (shift_q[c]),
      .range_i    (range_q[c]),
      .res_o      (res[c])
    );
  end

  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata  = {5'b0, res[2], res[1], res[0]};

  // Assertions.
  logic signed [OUT_W-1:0] min0, max0;
  assign min0 = range_q[0][OUT_W-1:0];
  assign max0 = range_q[0][RANGE_W-1:OUT_W];

  a_accept_fills_stage1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> v1_q)
    else $error("accepted request did not reach the first stage");

  a_stage3_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && rdy4) |=> v4_q)
    else $error("rounded value lost between stages three and four");

  a_full_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && v2_q && v3_q && v4_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while every stage is stalled");

  a_red_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (min0 <= max0)) |-> ((res[0] >= min0) && (res[0] <= max0)))
    else $error("first component outside its clip range");

endmodule

@@ verif/inverse_color_transform_clip_unit_tb.sv @@
// Self-checking testbench for inverse_color_transform_clip_unit: inverse RCT / ICT,
// rounding, level shift and clipping checked pixel by pixel against a predictor.
// Depends on icct_pkg and the unit's RTL; needs nothing else.
`timescale 1ns / 1ps

module inverse_color_transform_clip_unit_tb;
  import icct_pkg::*;

  // Unused mode code and a register index beyond the last register.
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = CFG_IDX_W'(7);

  // ICT coefficients in fixed point, truncated towards zero.
  localparam longint K_RV = (longint'(1402) << FRAC_BITS) / 1000;
  localparam longint K_GU = (longint'(34413) << FRAC_BITS) / 100000;
  localparam longint K_GV = (longint'(71414) << FRAC_BITS) / 100000;
  localparam longint K_BU = (longint'(1772) << FRAC_BITS) / 1000;

  localparam int PIPE_DEPTH = 4;
  localparam int RAND_PHASES = 12;
  localparam int PHASE_PIXELS = 111;
  localparam int HOLD_PHASE = 2;
  localparam int HOLD_CYCLES = 300;
  localparam int unsigned RUN_LIMIT_NS = 3_000_000;

  // One output pixel: red in element 0, as on the output bus.
  typedef logic [2:0][OUT_W-1:0] pixel_t;

  // Predicts the clipped RGB of each accepted request and checks the results.
  class rgb_scoreboard;
    logic [1:0] mode;
    logic signed [OUT_W-1:0] lvl_shift[3];
    logic [RANGE_W-1:0] bounds[3];
    pixel_t rgb_expected_q[$];
    int unsigned errors;
    string comp_name[3] = '{"red", "green", "blue"};

    function new();
      mode = MODE_RCT_INT;
      errors = 0;
      for (int c = 0; c < 3; c++) begin
        lvl_shift[c] = '0;
        bounds[c] = CLIP_RANGE_RST;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_MODE:    mode = data[1:0];
        REG_SHIFT_0: lvl_shift[0] = data[OUT_W-1:0];
        REG_SHIFT_1: lvl_shift[1] = data[OUT_W-1:0];
        REG_SHIFT_2: lvl_shift[2] = data[OUT_W-1:0];
        REG_RANGE_0: bounds[0] = data;
        REG_RANGE_1: bounds[1] = data;
        REG_RANGE_2: bounds[2] = data;
        default: ;
      endcase
    endfunction

    // Nearest integer, ties away from zero.
    function longint round_fix(longint x);
      longint half;
      half = longint'(1) <<< (FRAC_BITS - 1);
      if (x > 0) return (x + half) >>> FRAC_BITS;
      return -((-x + half) >>> FRAC_BITS);
    endfunction

    // Level shift, then the minimum test before the maximum test.
    function longint shift_clip(longint x, logic signed [OUT_W-1:0] sh,
                                logic [RANGE_W-1:0] rg);
      longint lo, hi;
      lo = $signed(rg[OUT_W-1:0]);
      hi = $signed(rg[RANGE_W-1:OUT_W]);
      x = x + sh;
      if (x < lo) return lo;
      if (x > hi) return hi;
      return x;
    endfunction

    function void predict_pixel(logic [3*IN_W-1:0] word);
      longint y, u, v;
      longint comp[3];
      pixel_t p;
      y = $signed(word[IN_W-1:0]);
      u = $signed(word[2*IN_W-1:IN_W]);
      v = $signed(word[3*IN_W-1:2*IN_W]);
      if (mode <= MODE_RCT_FIX) begin
        comp[1] = y - ((u + v) >>> 2);
        comp[0] = v + comp[1];
        comp[2] = u + comp[1];
      end else begin
        comp[0] = y + ((K_RV * v) >>> FRAC_BITS);
        comp[1] = y + ((-K_GU * u) >>> FRAC_BITS) + ((-K_GV * v) >>> FRAC_BITS);
        comp[2] = y + ((K_BU * u) >>> FRAC_BITS);
      end
      for (int c = 0; c < 3; c++) begin
        if (mode != MODE_RCT_INT) comp[c] = round_fix(comp[c]);
        p[c] = OUT_W'(shift_clip(comp[c], lvl_shift[c], bounds[c]));
      end
      rgb_expected_q.push_back(p);
    endfunction

    function void note_error(string msg);
      if (errors < 10) $display("mismatch: %s", msg);
      errors++;
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (rgb_expected_q.size() == 0) begin
        note_error($sformatf("result %h with no request outstanding", got));
        return;
      end
      want = rgb_expected_q.pop_front();
      for (int c = 0; c < 3; c++)
        if (got[c] !== want[c])
          note_error($sformatf("%s expected %0d, got %0d", comp_name[c],
                               $signed(want[c]), $signed(got[c])));
    endfunction

    function int pending();
      return rgb_expected_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [3*IN_W-1:0] s_axis_tdata;  // luma_in, chroma_b_in, chroma_r_in
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [55:0] m_axis_tdata;        // red_out, green_out, blue_out, zero pad

  rgb_scoreboard sb = new();
  bit send_idle;
  bit recv_idle;
  int hold_off_cycles;

  inverse_color_transform_clip_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Track configuration writes, accepted requests and results at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && cfg_we_i) sb.write_reg(cfg_idx_i, cfg_wdata_i);
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) sb.predict_pixel(s_axis_tdata);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_pixel(m_axis_tdata[3*OUT_W-1:0]);
  end

  // Output side: a random stall before each result when recv_idle is set, or a long hold-off on request.
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_cycles != 0) begin
        stall = hold_off_cycles;
        hold_off_cycles = 0;
      end else begin
        stall = recv_idle ? $urandom_range(0, 19) : 0;
      end
      if (stall != 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Offer one request, after a random gap when send_idle is set, and wait until it is taken.
  task automatic send_pixel(input logic [3*IN_W-1:0] word);
    int gap;
    gap = send_idle ? $urandom_range(0, 19) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = word;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic end_burst();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  // Every pixel yields a result, so an empty queue means the pipeline is empty.
  task automatic wait_results_done();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 2) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic logic [RANGE_W-1:0] pack_range(int lo, int hi);
    return {OUT_W'(hi), OUT_W'(lo)};
  endfunction

  // Zeros, field extremes, mixed signs and half-way values for the rounding.
  function automatic logic [3*IN_W-1:0] directed_pixel(int k);
    case (k)
      0: return '0;
      1: return {3{32'h7fff_ffff}};
      2: return {3{32'h8000_0000}};
      3: return {32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff};
      4: return {32'd0, 32'd0, 32'd4096};
      default: return {32'd0, 32'd0, -32'sd4096};
    endcase
  endfunction

  task automatic directed_burst();
    for (int k = 0; k < 6; k++) send_pixel(directed_pixel(k));
    end_burst();
    wait_results_done();
  endtask

  // Mostly samples of moderate size so that results are not all clipped.
  function automatic logic [IN_W-1:0] rand_sample(logic [1:0] mode);
    logic [IN_W-1:0] raw;
    int w;
    raw = $urandom;
    case ($urandom_range(0, 7))
      0: return raw;
      1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: begin
        w = (mode == MODE_RCT_INT) ? $urandom_range(2, 18) : $urandom_range(8, 31);
        raw = raw << (IN_W - w);
        return $signed(raw) >>> (IN_W - w);
      end
    endcase
  endfunction

  function automatic logic [OUT_W-1:0] rand_shift();
    logic signed [OUT_W-1:0] t;
    t = OUT_W'($urandom);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 17'h10000;
      2: return 17'h0ffff;
      default: return t >>> $urandom_range(0, 16);
    endcase
  endfunction

  function automatic logic [RANGE_W-1:0] rand_range();
    logic signed [OUT_W-1:0] t;
    int lo, hi;
    t = OUT_W'($urandom);
    case ($urandom_range(0, 5))
      0: return pack_range(-65536, 65535);
      1: return CLIP_RANGE_RST;
      2: return pack_range($urandom_range(0, 1000), -$urandom_range(0, 1000));
      default: begin
        lo = t >>> $urandom_range(0, 16);
        hi = lo + $urandom_range(0, 70000);
        if (hi > 65535) hi = 65535;
        return pack_range(lo, hi);
      end
    endcase
  endfunction

  // Stimulus and the final verdict.
  initial begin
    logic [1:0] mode;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    send_idle = 1'b0;
    recv_idle = 1'b0;
    hold_off_cycles = 0;
    rst_ni = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings, with a write to a missing register that must change nothing.
    cfg_write(REG_NONE, '1);
    directed_burst();

    // Extreme shifts and bounds, one component with its minimum above its maximum.
    cfg_write(REG_SHIFT_0, CFG_DATA_W'(17'h10000));
    cfg_write(REG_SHIFT_1, CFG_DATA_W'(17'h0ffff));
    cfg_write(REG_SHIFT_2, '0);
    cfg_write(REG_RANGE_0, pack_range(-65536, 65535));
    cfg_write(REG_RANGE_1, pack_range(0, 255));
    cfg_write(REG_RANGE_2, pack_range(100, -100));
    cfg_write(REG_MODE, CFG_DATA_W'(MODE_RCT_FIX));
    directed_burst();
    cfg_write(REG_MODE, CFG_DATA_W'(MODE_ICT));
    directed_burst();
    cfg_write(REG_MODE, CFG_DATA_W'(MODE_SPARE));
    directed_burst();

    // Random phases; unused upper bits of the narrow registers carry noise.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      mode = 2'($urandom_range(0, 3));
      send_idle = (ph != 0) && (ph != HOLD_PHASE) && ($urandom_range(0, 1) != 0);
      recv_idle = (ph != 0) && ($urandom_range(0, 1) != 0);
      cfg_write(REG_MODE, {32'($urandom), mode});
      cfg_write(REG_SHIFT_0, {17'($urandom), rand_shift()});
      cfg_write(REG_SHIFT_1, {17'($urandom), rand_shift()});
      cfg_write(REG_SHIFT_2, {17'($urandom), rand_shift()});
      cfg_write(REG_RANGE_0, rand_range());
      cfg_write(REG_RANGE_1, rand_range());
      cfg_write(REG_RANGE_2, rand_range());
      for (int i = 0; i < PHASE_PIXELS; i++) begin
        // The output holds off for a long stretch while requests keep coming.
        if (ph == HOLD_PHASE && i == 10) hold_off_cycles = HOLD_CYCLES;
        send_pixel({rand_sample(mode), rand_sample(mode), rand_sample(mode)});
      end
      end_burst();
      wait_results_done();
    end

    repeat (4 * PIPE_DEPTH) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #(RUN_LIMIT_NS);
    $display("Some tests failed");
    $finish;
  end

endmodule
